// File: src/assert_macros.svh
// Assertion macros used by the checker file buv_check.sv.
// Depends on a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, masked while reset is asserted.
`define BUV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BUV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: src/buv_pkg.sv
// Shared constants for the box union volume block: field widths, error codes, defaults.
// No dependencies.
package buv_pkg;

    localparam int COORD_W     = 8;
    localparam int VOL_W       = 64;
    localparam int ERR_W       = 2;

    localparam int MAX_POINTS_DEF = 16;
    localparam int MAX_DIMS_DEF   = 8;
    localparam int COORD_BITS_DEF = 8;

    localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_POINTS  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_DIMS    = 2'd2;
    localparam logic [ERR_W-1:0] ERR_UNEQUAL = 2'd3;

endpackage

// File: src/box_union_volume_incl_excl.sv
// Load: one coordinate word per cycle, busy low; the set-end word starts evaluation.
// Evaluation of n points in d dims runs over the 2^n-1 subsets S of the points, using one
// point-store read port, one compare and one 64x8 multiplier, then a result state. A set
// with an error gives its result in the cycle after the set-end word.
// Results are strobed by o_valid for one cycle; busy stays high up to and including the strobe.
// Synchronous active-low reset clears control; the point store is never cleared.
module box_union_volume_incl_excl #(
    parameter int MAX_POINTS = buv_pkg::MAX_POINTS_DEF,
    parameter int MAX_DIMS   = buv_pkg::MAX_DIMS_DEF,
    parameter int COORD_BITS = buv_pkg::COORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [buv_pkg::COORD_W-1:0] i_coord,
    input  logic                       i_end_of_point,
    input  logic                       i_end_of_set,
    output logic                       o_valid,
    output logic [buv_pkg::VOL_W-1:0]  o_volume,
    output logic [buv_pkg::ERR_W-1:0]  o_error
);
    import buv_pkg::*;

    localparam int PC_W   = $clog2(MAX_POINTS + 1);
    localparam int CIP_W  = $clog2(MAX_DIMS + 1);
    localparam int PI_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int DI_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int MASK_W = MAX_POINTS;
    localparam int DEPTH  = MAX_POINTS << DI_W;
    localparam int MUL_W  = VOL_W + COORD_BITS;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_ACC   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]            r_state;
    logic [PC_W-1:0]       r_pcnt, n_pcnt;
    logic [CIP_W-1:0]      r_dim, n_dim;
    logic [CIP_W-1:0]      r_cip, n_cip;
    logic [ERR_W-1:0]      r_err, n_err;
    logic [MASK_W-1:0]     r_mask, r_last, n_last;
    logic [VOL_W-1:0]      r_acc, n_acc;
    logic [VOL_W-1:0]      r_prod;
    logic [VOL_W-1:0]      r_vol;
    logic [ERR_W-1:0]      r_eout;
    logic [PI_W-1:0]       r_pi;
    logic [DI_W-1:0]       r_k;
    logic                  r_first;
    logic                  r_par;
    logic                  r_tag_v;
    logic [DI_W-1:0]       r_tag_k;
    logic                  r_tag_first;
    logic [COORD_BITS-1:0] r_rdata;
    logic [COORD_BITS-1:0] r_min [MAX_DIMS];
    logic [COORD_BITS-1:0] mem [DEPTH];

    logic                  accept;
    logic                  wr_en;
    logic [COORD_BITS-1:0] coord_m;
    logic                  issue;
    logic                  i_last;
    logic                  k_last;
    logic [DI_W-1:0]       min_idx;
    logic [COORD_BITS-1:0] min_rd;
    logic [MUL_W-1:0]      mul_full;

    assign accept  = start && !busy;
    assign busy    = (r_state != S_LOAD);
    assign coord_m = i_coord[COORD_BITS-1:0];
    assign issue   = (r_state == S_SCAN) && r_mask[r_pi];
    assign i_last  = (PC_W'(r_pi) == (r_pcnt - PC_W'(1)));
    assign k_last  = (CIP_W'(r_k) == (r_dim - CIP_W'(1)));
    assign min_idx = (r_state == S_MUL) ? r_k : r_tag_k;
    assign min_rd  = r_min[min_idx];
    assign mul_full = MUL_W'(r_prod) * MUL_W'(min_rd);
    assign n_acc   = r_par ? (r_acc + r_prod) : (r_acc - r_prod);

    assign o_valid  = (r_state == S_DONE);
    assign o_volume = r_vol;
    assign o_error  = r_eout;

    // load-side bookkeeping for the accepted word
    always_comb begin
        n_err = r_err;
        n_cip = r_cip;
        n_pcnt = r_pcnt;
        n_dim = r_dim;
        wr_en = 1'b0;
        if (accept) begin
            if (r_err == ERR_NONE) begin
                if (r_cip >= CIP_W'(MAX_DIMS)) begin
                    n_err = ERR_DIMS;
                end else if (r_pcnt >= PC_W'(MAX_POINTS)) begin
                    n_err = ERR_POINTS;
                end else begin
                    wr_en = 1'b1;
                    n_cip = r_cip + CIP_W'(1);
                end
            end
            if (i_end_of_point || i_end_of_set) begin
                if (n_err == ERR_NONE) begin
                    if (r_pcnt == '0) begin
                        n_dim = n_cip;
                    end else if (n_cip != r_dim) begin
                        n_err = ERR_UNEQUAL;
                    end
                    if (n_err == ERR_NONE) begin
                        n_pcnt = r_pcnt + PC_W'(1);
                    end
                end
                n_cip = '0;
            end
        end
    end

    // all-ones over the loaded points marks the last subset
    always_comb begin
        for (int j = 0; j < MASK_W; j++) begin
            n_last[j] = (PC_W'(j) < n_pcnt);
        end
    end

    // point store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[{r_pcnt[PI_W-1:0], r_cip[DI_W-1:0]}] <= coord_m;
        end
        r_rdata <= mem[{r_pi, r_k}];
    end

    // running minimum, updated from the registered read data in the cycle after each store read
    always_ff @(posedge i_clk) begin
        if (r_tag_v && (r_tag_first || (r_rdata < min_rd))) begin
            r_min[r_tag_k] <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_pcnt  <= '0;
            r_dim   <= '0;
            r_cip   <= '0;
            r_err   <= ERR_NONE;
            r_mask  <= '0;
            r_acc   <= '0;
            r_tag_v <= 1'b0;
        end else begin
            r_tag_v     <= issue;
            r_tag_k     <= r_k;
            r_tag_first <= r_first;
            unique case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        r_cip  <= n_cip;
                        r_err  <= n_err;
                        r_pcnt <= n_pcnt;
                        r_dim  <= n_dim;
                        if (i_end_of_set) begin
                            if (n_err != ERR_NONE) begin
                                r_vol   <= '0;
                                r_eout  <= n_err;
                                r_state <= S_DONE;
                            end else begin
                                r_last  <= n_last;
                                r_mask  <= MASK_W'(1);
                                r_acc   <= '0;
                                r_pi    <= '0;
                                r_k     <= '0;
                                r_first <= 1'b1;
                                r_par   <= 1'b0;
                                r_prod  <= VOL_W'(1);
                                r_state <= S_SCAN;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    if (r_mask[r_pi]) begin
                        if (k_last) begin
                            r_k     <= '0;
                            r_first <= 1'b0;
                            r_par   <= ~r_par;
                            if (i_last) begin
                                r_state <= S_DRAIN;
                            end else begin
                                r_pi <= r_pi + PI_W'(1);
                            end
                        end else begin
                            r_k <= r_k + DI_W'(1);
                        end
                    end else if (i_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_pi <= r_pi + PI_W'(1);
                    end
                end
                S_DRAIN: begin
                    // last minimum update lands this cycle
                    r_k     <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= mul_full[VOL_W-1:0];
                    if (k_last) begin
                        r_k     <= '0;
                        r_state <= S_ACC;
                    end else begin
                        r_k <= r_k + DI_W'(1);
                    end
                end
                S_ACC: begin
                    r_acc <= n_acc;
                    if (r_mask == r_last) begin
                        r_vol   <= n_acc;
                        r_eout  <= ERR_NONE;
                        r_state <= S_DONE;
                    end else begin
                        r_mask  <= r_mask + MASK_W'(1);
                        r_pi    <= '0;
                        r_k     <= '0;
                        r_first <= 1'b1;
                        r_par   <= 1'b0;
                        r_prod  <= VOL_W'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_DONE: begin
                    r_pcnt  <= '0;
                    r_dim   <= '0;
                    r_cip   <= '0;
                    r_err   <= ERR_NONE;
                    r_acc   <= '0;
                    r_mask  <= '0;
                    r_state <= S_LOAD;
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule

// File: src/buv_check.sv
// Port-level checker for box_union_volume_incl_excl, attached by bind.
// Depends on buv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module buv_check (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        i_end_of_set,
    input logic                        o_valid,
    input logic [buv_pkg::VOL_W-1:0]   o_volume,
    input logic [buv_pkg::ERR_W-1:0]   o_error
);
    import buv_pkg::*;

    `BUV_ASSERT(a_err_zero_vol, (o_valid && (o_error != ERR_NONE)) |-> (o_volume == '0), "error result with nonzero volume")
    `BUV_ASSERT(a_eos_busy, (start && !busy && i_end_of_set) |=> busy, "not busy after set end word")
    `BUV_ASSERT(a_word_ready, (start && !busy && !i_end_of_set) |=> (!busy && !o_valid), "stalled after a plain word")
    `BUV_ASSERT(a_result_once, o_valid |-> (busy ##1 (!busy && !o_valid)), "result not single or not followed by ready")
    `BUV_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!busy && !o_valid), "not idle after reset")

endmodule

bind box_union_volume_incl_excl buv_check u_buv_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_end_of_set (i_end_of_set),
    .o_valid      (o_valid),
    .o_volume     (o_volume),
    .o_error      (o_error)
);
